/* rtl/feedback_delay_echo_defines.svh */
// assertion macros shared by the echo rtl
`ifndef FEEDBACK_DELAY_ECHO_DEFINES_SVH
`define FEEDBACK_DELAY_ECHO_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define FDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define FDE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/fde_pkg.sv */
// package with register codes and fixed constants of the echo block
package fde_pkg;

  localparam int CFG_DATA_BITS = 17;
  localparam int GAIN_BITS     = 16;
  localparam int MIX_BITS      = 17;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2
  } reg_idx_t;

  localparam logic [GAIN_BITS-1:0] FEEDBACK_CAP   = 16'd62259;
  localparam logic [GAIN_BITS-1:0] FEEDBACK_RESET = 16'd19661;
  localparam logic [MIX_BITS-1:0]  MIX_ONE        = 17'd65536;
  localparam logic [MIX_BITS-1:0]  MIX_RESET      = 17'd32768;
  localparam int                   DELAY_RESET    = 22050;

endpackage

/* rtl/fde_store.sv */
// delay store: synchronous memory with write forwarding and fill tracking
`include "feedback_delay_echo_defines.svh"

module fde_store #(
  parameter int DEPTH = 131072,
  parameter int WIDTH = 16,
  parameter int AW    = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  localparam logic [AW:0] FILL_MAX = (AW+1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q;
  logic [AW-1:0]    rd_addr_q;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [WIDTH-1:0] fwd_data;
  logic [AW:0]      fill;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      fill      <= '0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
      if (fill < FILL_MAX) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // entries at or past the fill count read as zero, as the memory itself has no reset
  always_comb begin
    if (fwd_valid && fwd_addr == rd_addr_q) begin
      rd_data = fwd_data;
    end else if ((AW+1)'(rd_addr_q) < fill) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

  `FDE_ASSERT_NEVER(a_fill_range, fill > FILL_MAX, "fill count above store depth")
  `FDE_ASSERT(a_fill_order, (wr_en && fill < FILL_MAX) |-> (wr_addr == fill[AW-1:0]), "write off fill order")

endmodule

/* rtl/feedback_delay_echo.sv */
// top level of the feedback delay echo
// each transaction passes the stage 1, stage 2 and output registers in turn, and each holds under a stall
// throughput: one transaction per cycle while out_stall is low, set by one store read and one write per cycle
// bypass transactions take the same path and leave store and pointer untouched
// reset clears pointer, fill count, valid flags and settings at once; no clearing pass,
// store entries not yet written since reset read as zero
`include "feedback_delay_echo_defines.svh"

module feedback_delay_echo import fde_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          bypass,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DW = (AW + 1 > CFG_DATA_BITS) ? AW + 1 : CFG_DATA_BITS;
  localparam logic [AW-1:0] DELAY_MAX  = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] DELAY_INIT =
    AW'((DELAY_RESET > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : DELAY_RESET);
  localparam logic [AW:0]   DEPTH_W    = (AW+1)'(STORE_DEPTH);
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // configuration
  logic [AW-1:0]        delay;
  logic [GAIN_BITS-1:0] fb_gain;
  logic [MIX_BITS-1:0]  mix;
  logic [MIX_BITS-1:0]  dry;
  logic [MIX_BITS-1:0]  mix_wr;

  // handshake
  logic out_en;
  logic s2_en;
  logic s1_en;
  logic in_acc;

  // pointer and read address
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [AW:0]   rp_wide;
  logic [AW-1:0] rp;

  // stage 1
  logic                 s1_valid;
  logic                 s1_bypass;
  logic signed [SB-1:0] s1_sample;
  logic [AW-1:0]        s1_waddr;
  logic signed [SB-1:0] delayed;
  logic signed [SB+16:0] fb_prod;
  logic signed [SB+1:0]  fb_sum;
  logic signed [SB-1:0]  stored;
  logic signed [SB+17:0] dry_prod;
  logic signed [SB+17:0] wet_prod;
  logic                  st_wr;

  // stage 2
  logic                  s2_valid;
  logic                  s2_bypass;
  logic signed [SB-1:0]  s2_sample;
  logic signed [SB+17:0] s2_dry;
  logic signed [SB+17:0] s2_wet;
  logic signed [SB+18:0] mix_sum;
  logic signed [SB+2:0]  mix_sh;
  logic signed [SB-1:0]  mixed;

  assign mix_wr = (cfg_data > MIX_ONE) ? MIX_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay   <= DELAY_INIT;
      fb_gain <= FEEDBACK_RESET;
      mix     <= MIX_RESET;
      dry     <= MIX_ONE - MIX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY: begin
          delay <= (DW'(cfg_data) > DW'(DELAY_MAX)) ? DELAY_MAX : AW'(cfg_data);
        end
        REG_FEEDBACK: begin
          fb_gain <= (cfg_data[GAIN_BITS-1:0] > FEEDBACK_CAP) ? FEEDBACK_CAP
                                                              : cfg_data[GAIN_BITS-1:0];
        end
        REG_WET: begin
          mix <= mix_wr;
          dry <= MIX_ONE - mix_wr;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_en   = !out_valid || !out_stall;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;
  assign in_acc   = in_valid && s1_en;

  assign wp_next = (wp == DELAY_MAX) ? '0 : wp + 1'b1;
  assign rp_wide = (wp >= delay) ? (AW+1)'(wp) - (AW+1)'(delay)
                                 : (AW+1)'(wp) + DEPTH_W - (AW+1)'(delay);
  assign rp      = rp_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (in_acc && !bypass) begin
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_bypass <= bypass;
      s1_sample <= in_sample;
      s1_waddr  <= wp;
    end
  end

  assign st_wr = s1_valid && !s1_bypass && s2_en;

  fde_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SB),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s1_en),
    .rd_addr (rp),
    .wr_en   (st_wr),
    .wr_addr (s1_waddr),
    .wr_data (stored),
    .rd_data (delayed)
  );

  // feedback path, floor of the gain product then saturate
  assign fb_prod = delayed * $signed({1'b0, fb_gain});
  assign fb_sum  = {{2{s1_sample[SB-1]}}, s1_sample} + {fb_prod[SB+16], fb_prod[SB+16:16]};

  always_comb begin
    if ((&fb_sum[SB+1:SB-1]) || !(|fb_sum[SB+1:SB-1])) begin
      stored = fb_sum[SB-1:0];
    end else if (fb_sum[SB+1]) begin
      stored = S_MIN;
    end else begin
      stored = S_MAX;
    end
  end

  assign dry_prod = s1_sample * $signed({1'b0, dry});
  assign wet_prod = delayed * $signed({1'b0, mix});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_bypass <= s1_bypass;
      s2_sample <= s1_sample;
      s2_dry    <= dry_prod;
      s2_wet    <= wet_prod;
    end
  end

  // dry/wet mix, floor shift by 16 then saturate
  assign mix_sum = {s2_dry[SB+17], s2_dry} + {s2_wet[SB+17], s2_wet};
  assign mix_sh  = mix_sum[SB+18:16];

  always_comb begin
    if ((&mix_sh[SB+2:SB-1]) || !(|mix_sh[SB+2:SB-1])) begin
      mixed = mix_sh[SB-1:0];
    end else if (mix_sh[SB+2]) begin
      mixed = S_MIN;
    end else begin
      mixed = S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_sample <= s2_bypass ? s2_sample : mixed;
    end
  end

  `FDE_ASSERT_NEVER(a_wp_range, (AW+1)'(wp) >= DEPTH_W, "write pointer beyond store depth")
  `FDE_ASSERT(a_full_stall, (s1_valid && s2_valid && out_valid && out_stall) |-> in_stall, "accept into full pipe")
  `FDE_ASSERT(a_write_advance, st_wr |=> s2_valid, "store write without stage advance")

endmodule

/* verif/echo_checker.sv */
// checker for the feedback delay echo: tracks the delay store, predicts and compares results
`timescale 1ns / 100ps

module echo_checker import fde_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          bypass,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_sample,
  output int                            outstanding,
  output int                            mismatch_count
);

  localparam int PTR_BITS = $clog2(STORE_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  sample_t                tap_mem [STORE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [16:0]            delay_len;
  logic [GAIN_BITS-1:0]   fb_gain;
  logic [MIX_BITS-1:0]    wet_share;
  sample_t                echo_expected [$];

  function automatic sample_t clamp_sample(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return sample_t'(hi);
    if (v < lo) return sample_t'(lo);
    return sample_t'(v);
  endfunction

  // one transaction: read tap, write feedback sum, mix dry and wet; bypass passes x
  function automatic sample_t echo_step(sample_t x, logic byp);
    longint dly;
    longint fb;
    longint mix;
    longint rd;
    longint delayed;
    longint mixed;
    if (byp) return x;
    dly = longint'(delay_len);
    if (dly > STORE_DEPTH - 1) dly = STORE_DEPTH - 1;
    fb  = longint'((fb_gain > FEEDBACK_CAP) ? FEEDBACK_CAP : fb_gain);
    mix = longint'((wet_share > MIX_ONE) ? MIX_ONE : wet_share);
    rd  = (longint'(wr_ptr) - dly + STORE_DEPTH) % STORE_DEPTH;
    delayed = longint'(tap_mem[rd]);
    tap_mem[wr_ptr] = clamp_sample(longint'(x) + ((delayed * fb) >>> 16));
    wr_ptr = (wr_ptr == PTR_BITS'(STORE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    mixed = longint'(x) * (longint'(MIX_ONE) - mix) + delayed * mix;
    return clamp_sample(mixed >>> 16);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      foreach (tap_mem[i]) tap_mem[i] = '0;
      wr_ptr         = '0;
      delay_len      = 17'(DELAY_RESET);
      fb_gain        = FEEDBACK_RESET;
      wet_share      = MIX_RESET;
      mismatch_count = 0;
      echo_expected.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DELAY:    delay_len = cfg_data[16:0];
          REG_FEEDBACK: fb_gain   = cfg_data[GAIN_BITS-1:0];
          REG_WET:      wet_share = cfg_data[MIX_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) echo_expected.push_back(echo_step(in_sample, bypass));
      if (out_valid && !out_stall) begin
        if (echo_expected.size() == 0) begin
          $error("out_sample: expected none, actual %0d", out_sample);
          mismatch_count++;
        end else begin
          want = echo_expected.pop_front();
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, actual %0d", want, out_sample);
            mismatch_count++;
          end
        end
      end
    end
    outstanding <= echo_expected.size();
  end

endmodule

/* verif/feedback_delay_echo_test.sv */
// testbench top for the feedback delay echo: stimulus, register setup and verdict
`timescale 1ns / 100ps

module feedback_delay_echo_test;
  import fde_pkg::*;

  localparam int STORE_DEPTH  = 131072;
  localparam int SAMPLE_BITS  = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 130;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t                  SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t                  SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CFG_DATA_BITS-1:0] DELAY_MAX  = CFG_DATA_BITS'(STORE_DEPTH - 1);
  localparam logic [CFG_DATA_BITS-1:0] WET_TOP    = {CFG_DATA_BITS{1'b1}};

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [1:0]               cfg_index = REG_DELAY;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  sample_t                  in_sample = '0;
  logic                     bypass    = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  sample_t                  out_sample;

  int outstanding;
  int mismatch_count;
  int in_idle_mode = 0;
  int stall_mode   = 0;
  int stall_run    = 0;
  int quiet_cycles = 0;

  feedback_delay_echo #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .bypass     (bypass),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  echo_checker #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .bypass         (bypass),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length(int mode);
    if (mode == 0 || $urandom_range(0, 9) >= mode * 3) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    int len;
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      len = gap_length(stall_mode);
      out_stall <= (len > 0);
      stall_run <= (len > 0) ? len - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input sample_t s, input logic byp);
    int gap;
    gap = gap_length(in_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    bypass    <= byp;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every transaction has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] dly,
                           input logic [CFG_DATA_BITS-1:0] fb,
                           input logic [CFG_DATA_BITS-1:0] wet);
    write_reg(REG_DELAY, dly);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_WET, wet);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_delay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_BITS'(1);
      2:       return DELAY_MAX;
      3:       return CFG_DATA_BITS'($urandom);
      default: return CFG_DATA_BITS'($urandom_range(2, 200));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_feedback();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_DATA_BITS'(FEEDBACK_CAP);
      2:       return CFG_DATA_BITS'($urandom_range(FEEDBACK_CAP + 1, 65535));
      3:       return CFG_DATA_BITS'($urandom_range(40000, FEEDBACK_CAP));
      default: return CFG_DATA_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_wet();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return MIX_ONE;
      2:       return CFG_DATA_BITS'($urandom_range(MIX_ONE + 1, WET_TOP));
      default: return CFG_DATA_BITS'($urandom_range(0, MIX_ONE));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: long delay, taps read unwritten store entries as zero
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item('0, 1'b0);
    send_item(-sample_t'(1), 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b1);
    settle();

    // one-sample delay, gains above their caps, saturating feedback
    configure(CFG_DATA_BITS'(1), CFG_DATA_BITS'(16'hFFFF), WET_TOP);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(sample_t'(12345), 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(sample_t'(1), 1'b0);
    settle();

    // zero delay reads the entry about to be overwritten, fully dry
    configure('0, CFG_DATA_BITS'(FEEDBACK_CAP), '0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(-sample_t'(1), 1'b0);
    send_item('0, 1'b0);
    settle();

    // longest delay, no feedback, fully wet
    configure(DELAY_MAX, '0, MIX_ONE);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(sample_t'(5), 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      in_idle_mode = p % 3;
      stall_mode   = (p / 3) % 3;
      configure(pick_delay(), pick_feedback(), pick_wet());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) == 0) settle();
        send_item(rand_sample(), $urandom_range(0, 9) == 0);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/fde_pkg.sv
rtl/fde_store.sv
rtl/feedback_delay_echo.sv
verif/echo_checker.sv
verif/feedback_delay_echo_test.sv
